// ===== rtl/fte_pkg.sv =====
package fte_pkg;

  // Default sizes, handed to the top level parameters
  localparam int DEF_TABLE_SLOTS = 64;
  localparam int DEF_HANDLE_BITS = 16;

  // Fixed field widths of the request and response
  localparam int OP_W        = 2;
  localparam int IN_HANDLE_W = 16;
  localparam int STATUS_W    = 3;
  localparam int SLOT_OUT_W  = 6;
  localparam int COUNT_OUT_W = 7;
  localparam int OUT_HANDLE_W = 16;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Operation codes
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;
  localparam logic [OP_W-1:0] OP_NEXT   = 2'd3;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_NEW     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_UPDATED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_HIT     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_MISS    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd4;

  typedef struct packed {
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [7:0]  proto;
  } key_t;

  localparam int KEY_W = $bits(key_t);

  typedef struct packed {
    logic [OP_W-1:0]        operation;
    logic [31:0]            src_ip;
    logic [31:0]            dst_ip;
    logic [15:0]            sport;
    logic [15:0]            dport;
    logic [7:0]             proto;
    logic [IN_HANDLE_W-1:0] value_handle;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic [SLOT_OUT_W-1:0]   slot;
    logic [COUNT_OUT_W-1:0]  entry_count;
    logic [31:0]             out_src_ip;
    logic [31:0]             out_dst_ip;
    logic [15:0]             out_sport;
    logic [15:0]             out_dport;
    logic [7:0]              out_proto;
    logic [OUT_HANDLE_W-1:0] out_handle;
  } rsp_t;

  // Decoded command passed from front to back
  typedef struct packed {
    logic                   op_insert;
    logic                   op_lookup;
    logic                   op_remove;
    logic                   op_next;
    key_t                   key;
    logic [IN_HANDLE_W-1:0] handle;
  } cmd_t;

endpackage

// ===== rtl/five_tuple_flow_table.sv =====
// Channel   Handshake              Payload   Direction
// request   req_valid / req_stall  req_data  in
// response  rsp_valid / rsp_stall  rsp_data  out
//
// In the back engine each request goes through key compare over all slots,
// priority encode, select and update with the key/handle RAM read, and
// response. The engine works on one request at a time; the front register
// and a two-entry queue take further requests meanwhile.
// Reset (rst, synchronous) clears the valid bits, count and handshakes; no
// clearing pass is needed. Either side may stall without losing a request.
module five_tuple_flow_table import fte_pkg::*; #(
  parameter int TABLE_SLOTS = DEF_TABLE_SLOTS,
  parameter int HANDLE_BITS = DEF_HANDLE_BITS
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req_data,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp_data
);

  logic push_valid;
  logic push_ready;
  cmd_t push_cmd;
  logic pop_valid;
  logic pop;
  cmd_t pop_cmd;

  fte_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req_data   (req_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  fte_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_cmd    (pop_cmd)
  );

  fte_engine #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (pop_valid),
    .q_cmd     (pop_cmd),
    .q_pop     (pop),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
  );

endmodule

// ===== rtl/fte_front.sv =====
module fte_front import fte_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req_data,
  output logic push_valid,
  input  logic push_ready,
  output cmd_t push_cmd
);

  logic held;
  cmd_t cmd;
  cmd_t cmd_next;
  logic take;

  // Decode the operation into one-hot flags and gather the key
  always_comb begin
    cmd_next = '0;
    cmd_next.key.src_ip   = req_data.src_ip;
    cmd_next.key.dst_ip   = req_data.dst_ip;
    cmd_next.key.sport    = req_data.sport;
    cmd_next.key.dport    = req_data.dport;
    cmd_next.key.proto    = req_data.proto;
    cmd_next.handle       = req_data.value_handle;
    case (req_data.operation)
      OP_INSERT: cmd_next.op_insert = 1'b1;
      OP_LOOKUP: cmd_next.op_lookup = 1'b1;
      OP_REMOVE: cmd_next.op_remove = 1'b1;
      OP_NEXT:   cmd_next.op_next   = 1'b1;
      default:   cmd_next.op_next   = 1'b1;
    endcase
  end

  // Hold one decoded request until the queue takes it
  assign req_stall  = held && !push_ready;
  assign take       = req_valid && !req_stall;
  assign push_valid = held;
  assign push_cmd   = cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (take) begin
      held <= 1'b1;
    end else if (push_ready) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cmd <= cmd_next;
    end
  end

endmodule

// ===== rtl/fte_queue.sv =====
module fte_queue import fte_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop,
  output cmd_t pop_cmd
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (fill != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_cmd    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  // Pointers wrap at the queue depth
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ===== rtl/fte_engine.sv =====
module fte_engine import fte_pkg::*; #(
  parameter int TABLE_SLOTS = DEF_TABLE_SLOTS,
  parameter int HANDLE_BITS = DEF_HANDLE_BITS
) (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  input  cmd_t q_cmd,
  output logic q_pop,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp_data
);

  localparam int SLOT_W = $clog2(TABLE_SLOTS);
  localparam int CNT_W  = $clog2(TABLE_SLOTS + 1);
  localparam int WORD_W = KEY_W + HANDLE_BITS;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_MATCH   = 3'd1;
  localparam logic [2:0] S_RESOLVE = 3'd2;
  localparam logic [2:0] S_SELECT  = 3'd3;
  localparam logic [2:0] S_RESULT  = 3'd4;

  // Index of the lowest set bit; zero when none is set
  function automatic logic [SLOT_W-1:0] lowest(input logic [TABLE_SLOTS-1:0] v);
    logic [TABLE_SLOTS-1:0] iso;
    logic [SLOT_W-1:0]      idx;
    iso = v & (~v + TABLE_SLOTS'(1));
    idx = '0;
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      if (iso[i]) begin
        idx = idx | SLOT_W'(i);
      end
    end
    return idx;
  endfunction

  logic [2:0]             state;
  cmd_t                   cmd;
  key_t                   cam [TABLE_SLOTS];
  logic [TABLE_SLOTS-1:0] valid;
  logic [CNT_W-1:0]       count;
  logic [TABLE_SLOTS-1:0] match_vec;
  logic [TABLE_SLOTS-1:0] match_comb;
  logic                   hit;
  logic [SLOT_W-1:0]      hit_idx;
  logic                   free_any;
  logic [SLOT_W-1:0]      free_idx;
  logic [STATUS_W-1:0]    res_status;
  logic [SLOT_W-1:0]      res_slot;
  logic                   res_handle_en;
  logic                   res_key_en;
  logic [WORD_W-1:0]      ram [TABLE_SLOTS];
  logic [WORD_W-1:0]      ram_rdata;
  logic                   out_free;

  // Select-stage signals
  logic [TABLE_SLOTS-1:0] above_mask;
  logic [TABLE_SLOTS-1:0] next_cand;
  logic                   next_any;
  logic [SLOT_W-1:0]      next_idx;
  logic                   sel_write;
  logic                   sel_new;
  logic                   sel_clear;
  logic [SLOT_W-1:0]      sel_addr;
  logic [STATUS_W-1:0]    sel_status;
  logic [SLOT_W-1:0]      sel_slot;
  logic                   sel_handle_en;
  logic                   sel_key_en;
  logic                   in_select;

  logic [HANDLE_BITS+IN_HANDLE_W-1:0]  h_ext;
  logic [HANDLE_BITS-1:0]              h_stored;
  logic [HANDLE_BITS+OUT_HANDLE_W-1:0] h_out_ext;
  logic [SLOT_W+SLOT_OUT_W-1:0]        slot_ext;
  logic [CNT_W+COUNT_OUT_W-1:0]        count_ext;
  key_t                                rd_key;
  rsp_t                                rsp_next;

  assign out_free  = !rsp_valid || !rsp_stall;
  assign q_pop     = q_valid && ((state == S_IDLE) || ((state == S_RESULT) && out_free));
  assign in_select = (state == S_SELECT);

  // Handle kept at HANDLE_BITS
  assign h_ext    = {{HANDLE_BITS{1'b0}}, cmd.handle};
  assign h_stored = h_ext[HANDLE_BITS-1:0];

  // Parallel key compare over every slot
  always_comb begin
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      match_comb[i] = valid[i] && (cam[i] == cmd.key);
    end
  end

  // Candidates for next: valid slots above a hit, or every valid slot on a miss
  always_comb begin
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      above_mask[i] = !hit || (SLOT_W'(i) > hit_idx);
    end
    next_cand = valid & above_mask;
    next_any  = |next_cand;
    next_idx  = lowest(next_cand);
  end

  // Decide the outcome and the slot touched
  always_comb begin
    sel_write     = 1'b0;
    sel_new       = 1'b0;
    sel_clear     = 1'b0;
    sel_addr      = hit_idx;
    sel_status    = ST_MISS;
    sel_slot      = '0;
    sel_handle_en = 1'b0;
    sel_key_en    = 1'b0;
    if (cmd.op_insert) begin
      if (hit) begin
        sel_write  = 1'b1;
        sel_status = ST_UPDATED;
        sel_slot   = hit_idx;
      end else if (free_any) begin
        sel_write  = 1'b1;
        sel_new    = 1'b1;
        sel_addr   = free_idx;
        sel_status = ST_NEW;
        sel_slot   = free_idx;
      end else begin
        sel_status = ST_FULL;
      end
    end else if (cmd.op_lookup || cmd.op_remove) begin
      if (hit) begin
        sel_status    = ST_HIT;
        sel_slot      = hit_idx;
        sel_handle_en = 1'b1;
        sel_clear     = cmd.op_remove;
      end
    end else begin
      sel_addr = next_idx;
      if (next_any) begin
        sel_status    = ST_HIT;
        sel_slot      = next_idx;
        sel_handle_en = 1'b1;
        sel_key_en    = 1'b1;
      end
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (q_valid) state <= S_MATCH;
        end
        S_MATCH:   state <= S_RESOLVE;
        S_RESOLVE: state <= S_SELECT;
        S_SELECT:  state <= S_RESULT;
        S_RESULT: begin
          if (out_free) state <= q_valid ? S_MATCH : S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Valid bits and entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      count <= '0;
    end else if (in_select) begin
      if (sel_new) begin
        valid[sel_addr] <= 1'b1;
        count           <= count + CNT_W'(1);
      end else if (sel_clear) begin
        valid[sel_addr] <= 1'b0;
        if (count != '0) count <= count - CNT_W'(1);
      end
    end
  end

  // Working registers of the current request
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd <= q_cmd;
    end
    if (state == S_MATCH) begin
      match_vec <= match_comb;
    end
    if (state == S_RESOLVE) begin
      hit      <= |match_vec;
      hit_idx  <= lowest(match_vec);
      free_any <= ~&valid;
      free_idx <= lowest(~valid);
    end
    if (in_select) begin
      res_status    <= sel_status;
      res_slot      <= sel_slot;
      res_handle_en <= sel_handle_en;
      res_key_en    <= sel_key_en;
    end
    if (in_select && sel_new) begin
      cam[sel_addr] <= cmd.key;
    end
  end

  // Key and handle copy for readout
  always_ff @(posedge clk) begin
    if (in_select && sel_write) begin
      ram[sel_addr] <= {cmd.key, h_stored};
    end
    ram_rdata <= ram[sel_addr];
  end

  // Assemble the response
  assign slot_ext  = {{SLOT_OUT_W{1'b0}}, res_slot};
  assign count_ext = {{COUNT_OUT_W{1'b0}}, count};
  assign h_out_ext = {{OUT_HANDLE_W{1'b0}}, ram_rdata[HANDLE_BITS-1:0]};
  assign rd_key    = res_key_en ? key_t'(ram_rdata[WORD_W-1:HANDLE_BITS]) : '0;

  always_comb begin
    rsp_next.status       = res_status;
    rsp_next.slot         = slot_ext[SLOT_OUT_W-1:0];
    rsp_next.entry_count  = count_ext[COUNT_OUT_W-1:0];
    rsp_next.out_src_ip   = rd_key.src_ip;
    rsp_next.out_dst_ip   = rd_key.dst_ip;
    rsp_next.out_sport    = rd_key.sport;
    rsp_next.out_dport    = rd_key.dport;
    rsp_next.out_proto    = rd_key.proto;
    rsp_next.out_handle   = res_handle_en ? h_out_ext[OUT_HANDLE_W-1:0] : '0;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if ((state == S_RESULT) && out_free) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_RESULT) && out_free) begin
      rsp_data <= rsp_next;
    end
  end

`ifndef SYNTHESIS
  // Count tracks the valid bits
  a_count: assert property (@(posedge clk) disable iff (rst)
    count == CNT_W'($countones(valid)))
    else $error("entry count out of step with valid bits");

  // Keys are unique, so a lookup hits one slot at most
  a_unique: assert property (@(posedge clk) disable iff (rst)
    (state == S_RESOLVE) |-> $onehot0(match_vec))
    else $error("key present in more than one slot");

  // Full reported only with every slot taken
  a_full: assert property (@(posedge clk) disable iff (rst)
    ((state == S_RESULT) && (res_status == ST_FULL)) |-> (count == CNT_W'(TABLE_SLOTS)))
    else $error("full reported with a free slot");

  // A remove that hits clears its slot
  a_remove: assert property (@(posedge clk) disable iff (rst)
    (in_select && sel_clear) |=> !valid[$past(sel_addr)])
    else $error("removed slot still valid");
`endif

endmodule

// ===== tb/sv/five_tuple_flow_table_tb.sv =====
`timescale 1ns / 1ps

module five_tuple_flow_table_tb;
  import fte_pkg::*;

  localparam int SLOTS = DEF_TABLE_SLOTS;

  logic clk;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req_data  = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp_data;

  five_tuple_flow_table u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
  );

  // Shadow copy of the flow table
  key_t        shadow_key[SLOTS];
  logic [15:0] shadow_handle[SLOTS];
  bit          shadow_used[SLOTS];
  int          shadow_count;

  rsp_t expected_rsp[$];
  int   mismatches = 0;
  bit   idle_on = 1'b0;
  int   rsp_hold = 0;
  key_t key_pool[128];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard limit on the run
  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < 100)
      $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Table behaviour for one request; updates the shadow copy
  function automatic rsp_t flow_table_result(input req_t r);
    rsp_t res;
    key_t k;
    int   hit;
    int   free_at;
    int   nxt;
    res = '0;
    res.status = ST_MISS;
    k = {r.src_ip, r.dst_ip, r.sport, r.dport, r.proto};
    hit = -1;
    free_at = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (hit < 0 && shadow_used[i] && shadow_key[i] == k) hit = i;
      if (free_at < 0 && !shadow_used[i]) free_at = i;
    end
    case (r.operation)
      OP_INSERT: begin
        if (hit >= 0) begin
          shadow_handle[hit] = r.value_handle;
          res.status = ST_UPDATED;
          res.slot = hit[5:0];
        end else if (free_at >= 0) begin
          shadow_key[free_at] = k;
          shadow_handle[free_at] = r.value_handle;
          shadow_used[free_at] = 1'b1;
          shadow_count++;
          res.status = ST_NEW;
          res.slot = free_at[5:0];
        end else begin
          res.status = ST_FULL;
        end
      end
      OP_LOOKUP, OP_REMOVE: begin
        if (hit >= 0) begin
          res.status = ST_HIT;
          res.slot = hit[5:0];
          res.out_handle = shadow_handle[hit];
          if (r.operation == OP_REMOVE) begin
            shadow_used[hit] = 1'b0;
            if (shadow_count > 0) shadow_count--;
          end
        end
      end
      default: begin
        // next: scan forward from the slot after a hit, or from zero
        nxt = -1;
        for (int i = hit + 1; i < SLOTS; i++)
          if (nxt < 0 && shadow_used[i]) nxt = i;
        if (nxt >= 0) begin
          res.status = ST_HIT;
          res.slot = nxt[5:0];
          res.out_handle = shadow_handle[nxt];
          res.out_src_ip = shadow_key[nxt].src_ip;
          res.out_dst_ip = shadow_key[nxt].dst_ip;
          res.out_sport = shadow_key[nxt].sport;
          res.out_dport = shadow_key[nxt].dport;
          res.out_proto = shadow_key[nxt].proto;
        end
      end
    endcase
    res.entry_count = shadow_count[6:0];
    return res;
  endfunction

  function automatic req_t make_req(input logic [OP_W-1:0] op, input key_t k,
                                    input logic [15:0] h);
    req_t r;
    r.operation = op;
    r.src_ip = k.src_ip;
    r.dst_ip = k.dst_ip;
    r.sport = k.sport;
    r.dport = k.dport;
    r.proto = k.proto;
    r.value_handle = h;
    return r;
  endfunction

  function automatic key_t random_key();
    key_t k;
    k.src_ip = $urandom;
    k.dst_ip = $urandom;
    k.sport = 16'($urandom_range(0, 65535));
    k.dport = 16'($urandom_range(0, 65535));
    k.proto = 8'($urandom_range(0, 255));
    return k;
  endfunction

  // Send one request; valid is left high so back-to-back requests need no gap
  task automatic send_request(input req_t r);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    expected_rsp.push_back(flow_table_result(r));
  endtask

  // Hold off new requests until every response is back
  task automatic wait_table_idle();
    req_valid <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Response side stalls in random bursts
  always @(posedge clk) begin
    if (rst || !idle_on) begin
      rsp_stall <= 1'b0;
      rsp_hold <= 0;
    end else if (rsp_hold > 0) begin
      rsp_hold <= rsp_hold - 1;
      rsp_stall <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      rsp_hold <= $urandom_range(0, 14);
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  // Compare each response with the oldest prediction
  always @(posedge clk) begin : rsp_check
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_rsp.size() == 0) begin
        report_mismatch("response with none expected", 32'(rsp_data.status), 0);
      end else begin
        want = expected_rsp.pop_front();
        if (rsp_data.status !== want.status)
          report_mismatch("status", 32'(rsp_data.status), 32'(want.status));
        if (rsp_data.slot !== want.slot)
          report_mismatch("slot", 32'(rsp_data.slot), 32'(want.slot));
        if (rsp_data.entry_count !== want.entry_count)
          report_mismatch("entry_count", 32'(rsp_data.entry_count),
                          32'(want.entry_count));
        if (rsp_data.out_src_ip !== want.out_src_ip)
          report_mismatch("out_src_ip", rsp_data.out_src_ip, want.out_src_ip);
        if (rsp_data.out_dst_ip !== want.out_dst_ip)
          report_mismatch("out_dst_ip", rsp_data.out_dst_ip, want.out_dst_ip);
        if (rsp_data.out_sport !== want.out_sport)
          report_mismatch("out_sport", 32'(rsp_data.out_sport), 32'(want.out_sport));
        if (rsp_data.out_dport !== want.out_dport)
          report_mismatch("out_dport", 32'(rsp_data.out_dport), 32'(want.out_dport));
        if (rsp_data.out_proto !== want.out_proto)
          report_mismatch("out_proto", 32'(rsp_data.out_proto), 32'(want.out_proto));
        if (rsp_data.out_handle !== want.out_handle)
          report_mismatch("out_handle", 32'(rsp_data.out_handle),
                          32'(want.out_handle));
      end
    end
  end

  // Empty table, extreme keys and handles, update, near miss, next scans
  task automatic test_directed();
    key_t kz;
    key_t k1;
    key_t k2;
    key_t k3;
    key_t k4;
    kz = '0;
    k1 = '1;
    k2 = k1;
    k2.proto = 8'hFE;
    k3 = random_key();
    k4 = kz;
    k4.sport = 16'hFFFF;
    send_request(make_req(OP_LOOKUP, kz, 16'h0));
    send_request(make_req(OP_NEXT, kz, 16'h0));
    send_request(make_req(OP_REMOVE, k1, 16'h0));
    send_request(make_req(OP_INSERT, kz, 16'h0000));
    send_request(make_req(OP_INSERT, k1, 16'hFFFF));
    send_request(make_req(OP_INSERT, k1, 16'h1234));
    send_request(make_req(OP_LOOKUP, k1, 16'hFFFF));
    send_request(make_req(OP_LOOKUP, k2, 16'h0));
    send_request(make_req(OP_INSERT, k2, 16'h5555));
    send_request(make_req(OP_NEXT, kz, 16'h0));
    send_request(make_req(OP_NEXT, k1, 16'h0));
    send_request(make_req(OP_NEXT, k2, 16'h0));
    send_request(make_req(OP_NEXT, k3, 16'h0));
    send_request(make_req(OP_REMOVE, kz, 16'h0));
    send_request(make_req(OP_LOOKUP, kz, 16'h0));
    send_request(make_req(OP_NEXT, k3, 16'h0));
    send_request(make_req(OP_INSERT, k3, 16'hAAAA));
    send_request(make_req(OP_INSERT, k4, 16'h00FF));
    send_request(make_req(OP_REMOVE, k1, 16'h0));
    send_request(make_req(OP_REMOVE, k2, 16'h0));
    send_request(make_req(OP_REMOVE, k3, 16'h0));
    send_request(make_req(OP_REMOVE, k4, 16'h0));
    wait_table_idle();
  endtask

  // Fill every slot, then insert into the full table, update and refill
  task automatic test_full_table();
    key_t fill_keys[SLOTS];
    key_t extra;
    for (int i = 0; i < SLOTS; i++) begin
      fill_keys[i] = random_key();
      send_request(make_req(OP_INSERT, fill_keys[i], 16'($urandom_range(0, 65535))));
    end
    extra = random_key();
    send_request(make_req(OP_INSERT, extra, 16'h0BAD));
    send_request(make_req(OP_INSERT, fill_keys[SLOTS-1], 16'hFFFF));
    send_request(make_req(OP_NEXT, fill_keys[SLOTS-1], 16'h0));
    send_request(make_req(OP_LOOKUP, fill_keys[SLOTS-1], 16'h0));
    send_request(make_req(OP_REMOVE, fill_keys[17], 16'h0));
    send_request(make_req(OP_NEXT, fill_keys[16], 16'h0));
    send_request(make_req(OP_INSERT, extra, 16'h0BAD));
    send_request(make_req(OP_LOOKUP, extra, 16'h0));
    wait_table_idle();
  endtask

  // Random traffic over a pool of keys with some fully random keys mixed in
  task automatic test_random_traffic(input int n_items, input int pool_n,
                                     input int ins_pct, input int rem_pct,
                                     input bit near_keys);
    key_t             k;
    key_t             base;
    logic [OP_W-1:0]  op;
    int               roll;
    int               bitpos;
    base = random_key();
    for (int i = 0; i < pool_n; i++) begin
      if (near_keys && i[0]) begin
        // differ from the base key in a single bit
        bitpos = $urandom_range(0, KEY_W - 1);
        key_pool[i] = base ^ (key_t'(1) << bitpos);
      end else begin
        key_pool[i] = random_key();
      end
    end
    for (int n = 0; n < n_items; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < ins_pct) op = OP_INSERT;
      else if (roll < ins_pct + rem_pct) op = OP_REMOVE;
      else if (roll[0]) op = OP_LOOKUP;
      else op = OP_NEXT;
      if ($urandom_range(0, 9) == 0) k = random_key();
      else k = key_pool[$urandom_range(0, pool_n - 1)];
      send_request(make_req(op, k, 16'($urandom_range(0, 65535))));
    end
    wait_table_idle();
  endtask

  initial begin
    for (int i = 0; i < SLOTS; i++) shadow_used[i] = 1'b0;
    shadow_count = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    idle_on = 1'b1;
    test_directed();
    idle_on = 1'b0;
    test_full_table();
    idle_on = 1'b1;
    test_random_traffic(420, 96, 50, 15, 1'b0);
    test_random_traffic(400, 40, 20, 45, 1'b1);
    idle_on = 1'b0;
    test_random_traffic(450, 70, 35, 30, 1'b0);

    // tail: let any stray response show up
    repeat (40) @(posedge clk);
    if (expected_rsp.size() != 0)
      report_mismatch("responses still expected", expected_rsp.size(), 0);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/fte_pkg.sv
rtl/fte_front.sv
rtl/fte_queue.sv
rtl/fte_engine.sv
rtl/five_tuple_flow_table.sv
tb/sv/five_tuple_flow_table_tb.sv
